// ===== hdl/drbd_pkg.sv =====
package drbd_pkg;

  // Field widths
  localparam int VALUE_W    = 24;
  localparam int CLASS_W    = 8;
  localparam int PIX_W      = 12;
  localparam int SCALE_W    = 16;
  localparam int THR_W      = 13;
  localparam int LEN_W      = 7;
  localparam int PROD_W     = VALUE_W + SCALE_W + 1;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // Normalized boxes scale by image size in Q.12
  localparam int NORM_SHIFT  = 12;
  localparam int BOX_VALUES  = 4;
  localparam int MIN_ROW_LEN = 5;

  // Register reset values
  localparam logic [PIX_W-1:0]   RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [PIX_W-1:0]   RST_IMAGE_HEIGHT = 12'd640;
  localparam logic [SCALE_W-1:0] RST_SCALE_X      = 16'd4096;
  localparam logic [SCALE_W-1:0] RST_SCALE_Y      = 16'd4096;
  localparam logic [THR_W-1:0]   RST_THRESHOLD    = 13'd3072;
  localparam logic [LEN_W-1:0]   RST_ROW_LENGTH   = 7'd5;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_SCALE_X      = 3'd2,
    REG_SCALE_Y      = 3'd3,
    REG_THRESHOLD    = 3'd4,
    REG_ROW_LENGTH   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]   image_width;
    logic [PIX_W-1:0]   image_height;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [THR_W-1:0]   score_threshold;
    logic [LEN_W-1:0]   row_length;
  } cfg_t;

  // Finished row that passed the threshold
  typedef struct packed {
    logic signed [VALUE_W-1:0] cx;
    logic signed [VALUE_W-1:0] cy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic signed [VALUE_W-1:0] best_score;
    logic signed [CLASS_W-1:0] best_class;
  } row_res_t;

  // Scaled box, products before the final shift
  typedef struct packed {
    logic signed [PROD_W-1:0]  pcx;
    logic signed [PROD_W-1:0]  pcy;
    logic signed [PROD_W-1:0]  pw;
    logic signed [PROD_W-1:0]  ph;
    logic                      norm;
    logic signed [VALUE_W-1:0] best_score;
    logic signed [CLASS_W-1:0] best_class;
  } prod_t;

endpackage

// ===== hdl/drbd_if.sv =====
interface drbd_in_if import drbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface drbd_out_if import drbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PIX_W-1:0]          box_left;
  logic [PIX_W-1:0]          box_top;
  logic [PIX_W-1:0]          box_width;
  logic [PIX_W-1:0]          box_height;
  logic signed [CLASS_W-1:0] best_class;
  logic signed [VALUE_W-1:0] best_score;

  modport source(output valid, output box_left, output box_top, output box_width,
                 output box_height, output best_class, output best_score, input ready);
  modport sink(input valid, input box_left, input box_top, input box_width,
               input box_height, input best_class, input best_score, output ready);
endinterface

// ===== hdl/drbd_cfg.sv =====
module drbd_cfg import drbd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= RST_IMAGE_WIDTH;
      cfg_r.image_height    <= RST_IMAGE_HEIGHT;
      cfg_r.scale_x         <= RST_SCALE_X;
      cfg_r.scale_y         <= RST_SCALE_Y;
      cfg_r.score_threshold <= RST_THRESHOLD;
      cfg_r.row_length      <= RST_ROW_LENGTH;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  cfg_r.image_width     <= pwdata[PIX_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height    <= pwdata[PIX_W-1:0];
        REG_SCALE_X:      cfg_r.scale_x         <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y:      cfg_r.scale_y         <= pwdata[SCALE_W-1:0];
        REG_THRESHOLD:    cfg_r.score_threshold <= pwdata[THR_W-1:0];
        REG_ROW_LENGTH:   cfg_r.row_length      <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_r.image_height);
      REG_SCALE_X:      prdata = DATA_W'(cfg_r.scale_x);
      REG_SCALE_Y:      prdata = DATA_W'(cfg_r.scale_y);
      REG_THRESHOLD:    prdata = DATA_W'(cfg_r.score_threshold);
      REG_ROW_LENGTH:   prdata = DATA_W'(cfg_r.row_length);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/drbd_row.sv =====
module drbd_row import drbd_pkg::*; #(
  parameter int FRACTION_BITS = 12,
  parameter int MAX_CLASSES   = 80
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  cfg_t                      cfg,
  output logic                      row_valid,
  input  logic                      row_ready,
  output row_res_t                  row_data
);

  localparam int MAX_LEN = BOX_VALUES + MAX_CLASSES;
  localparam logic signed [VALUE_W-1:0] NEG_ONE = -VALUE_W'(1 << FRACTION_BITS);

  logic [LEN_W-1:0]          pos_r, pos_nxt;
  logic signed [VALUE_W-1:0] bv_r [BOX_VALUES];
  logic signed [VALUE_W-1:0] best_r, best_nxt;
  logic signed [CLASS_W-1:0] cls_r, cls_nxt;
  logic                      row_valid_r;
  row_res_t                  row_data_r;

  logic [LEN_W-1:0]          len_eff;
  logic                      single, is_box, upd, last_val, emit, accept;
  logic signed [VALUE_W-1:0] fin_score;
  logic signed [CLASS_W-1:0] fin_class;

  assign in_ready  = !row_valid_r || row_ready;
  assign accept    = in_valid && in_ready;
  assign row_valid = row_valid_r;
  assign row_data  = row_data_r;

  always_comb begin
    len_eff = cfg.row_length;
    if (cfg.row_length < LEN_W'(MIN_ROW_LEN)) begin
      len_eff = LEN_W'(MIN_ROW_LEN);
    end else if (int'(cfg.row_length) > MAX_LEN) begin
      len_eff = LEN_W'(MAX_LEN);
    end
    single   = (len_eff == LEN_W'(MIN_ROW_LEN));
    is_box   = (pos_r < LEN_W'(BOX_VALUES));
    upd      = !is_box && !single && (in_value > best_r);
    last_val = !is_box && (({1'b0, pos_r} + (LEN_W+1)'(1)) >= {1'b0, len_eff});

    // single-class row: the score value is the answer, class 0
    if (single) begin
      fin_score = in_value;
      fin_class = '0;
    end else if (upd) begin
      fin_score = in_value;
      fin_class = CLASS_W'(pos_r - LEN_W'(BOX_VALUES));
    end else begin
      fin_score = best_r;
      fin_class = cls_r;
    end
    emit = last_val && !(fin_score < $signed({1'b0, cfg.score_threshold}));

    pos_nxt  = pos_r;
    best_nxt = best_r;
    cls_nxt  = cls_r;
    if (accept) begin
      if (last_val) begin
        pos_nxt  = '0;
        best_nxt = NEG_ONE;
        cls_nxt  = '1;
      end else begin
        pos_nxt = pos_r + LEN_W'(1);
        if (upd) begin
          best_nxt = in_value;
          cls_nxt  = CLASS_W'(pos_r - LEN_W'(BOX_VALUES));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      best_r      <= NEG_ONE;
      cls_r       <= '1;
      row_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
      if (accept && emit) begin
        row_valid_r <= 1'b1;
      end else if (row_ready) begin
        row_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_box) begin
      bv_r[pos_r[1:0]] <= in_value;
    end
    if (accept && emit) begin
      row_data_r.cx         <= bv_r[0];
      row_data_r.cy         <= bv_r[1];
      row_data_r.w          <= bv_r[2];
      row_data_r.h          <= bv_r[3];
      row_data_r.best_score <= fin_score;
      row_data_r.best_class <= fin_class;
    end
  end

endmodule

// ===== hdl/drbd_scale.sv =====
module drbd_scale import drbd_pkg::*; #(
  parameter int FRACTION_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     row_valid,
  output logic     row_ready,
  input  row_res_t row_data,
  input  cfg_t     cfg,
  output logic     prod_valid,
  input  logic     prod_ready,
  output prod_t    prod_data
);

  localparam logic signed [VALUE_W-1:0] ONE = VALUE_W'(1 << FRACTION_BITS);

  logic                norm;
  logic [SCALE_W-1:0]  mx, my;
  logic                prod_valid_r;
  prod_t               prod_data_r;
  logic                load;

  assign row_ready  = !prod_valid_r || prod_ready;
  assign load       = row_valid && row_ready;
  assign prod_valid = prod_valid_r;
  assign prod_data  = prod_data_r;

  // normalized box: every coordinate at most 1.0
  always_comb begin
    norm = (row_data.cx <= ONE) && (row_data.cy <= ONE) &&
           (row_data.w <= ONE) && (row_data.h <= ONE);
    mx   = norm ? SCALE_W'(cfg.image_width)  : cfg.scale_x;
    my   = norm ? SCALE_W'(cfg.image_height) : cfg.scale_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (load) begin
      prod_valid_r <= 1'b1;
    end else if (prod_ready) begin
      prod_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_data_r.pcx        <= row_data.cx * $signed({1'b0, mx});
      prod_data_r.pcy        <= row_data.cy * $signed({1'b0, my});
      prod_data_r.pw         <= row_data.w  * $signed({1'b0, mx});
      prod_data_r.ph         <= row_data.h  * $signed({1'b0, my});
      prod_data_r.norm       <= norm;
      prod_data_r.best_score <= row_data.best_score;
      prod_data_r.best_class <= row_data.best_class;
    end
  end

endmodule

// ===== hdl/drbd_axis.sv =====
module drbd_axis import drbd_pkg::*; #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     norm,
  input  logic signed [PROD_W-1:0] p_c,
  input  logic signed [PROD_W-1:0] p_s,
  input  logic [PIX_W-1:0]         limit,
  output logic [PIX_W-1:0]         box_edge,
  output logic [PIX_W-1:0]         box_size
);

  localparam int X_W    = PROD_W + NORM_SHIFT;
  localparam int NUM_W  = X_W + 2;
  localparam int K_E    = FRACTION_BITS + 13;
  localparam int K_S    = FRACTION_BITS + 12;
  localparam int EDGE_W = NUM_W - K_E;
  localparam int SIZE_W = X_W - K_S;

  logic signed [X_W-1:0]    xc, xs, xs_adj;
  logic signed [NUM_W-1:0]  num, num_adj;
  logic signed [EDGE_W-1:0] q_e, q_e_r;
  logic signed [SIZE_W-1:0] q_s, q_s_r, size_c;
  logic [PIX_W-1:0]         lim_m1, edge_c;
  logic [PIX_W:0]           rem;

  // shift then divide, truncating toward zero
  always_comb begin
    xc      = norm ? (X_W'(p_c) <<< NORM_SHIFT) : X_W'(p_c);
    xs      = norm ? (X_W'(p_s) <<< NORM_SHIFT) : X_W'(p_s);
    num     = (NUM_W'(xc) <<< 1) - NUM_W'(xs);
    num_adj = num + (num[NUM_W-1] ? $signed({{(NUM_W-K_E){1'b0}}, {K_E{1'b1}}}) : '0);
    xs_adj  = xs + (xs[X_W-1] ? $signed({{(X_W-K_S){1'b0}}, {K_S{1'b1}}}) : '0);
    q_e     = EDGE_W'(num_adj >>> K_E);
    q_s     = SIZE_W'(xs_adj >>> K_S);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_e_r <= q_e;
      q_s_r <= q_s;
    end
  end

  // clamp edge to [0, limit-1], then size to [1, limit-edge]
  always_comb begin
    lim_m1 = (limit == '0) ? '0 : limit - PIX_W'(1);
    if (q_e_r < 0) begin
      edge_c = '0;
    end else if (q_e_r > $signed(EDGE_W'({1'b0, lim_m1}))) begin
      edge_c = lim_m1;
    end else begin
      edge_c = q_e_r[PIX_W-1:0];
    end
    rem = {1'b0, limit} - {1'b0, edge_c};
    if (q_s_r > $signed(SIZE_W'(rem))) begin
      size_c = $signed(SIZE_W'(rem));
    end else begin
      size_c = q_s_r;
    end
    if (size_c < $signed(SIZE_W'(1))) begin
      size_c = $signed(SIZE_W'(1));
    end
    box_edge = edge_c;
    box_size = size_c[PIX_W-1:0];
  end

endmodule

// ===== hdl/detection_row_box_decode.sv =====
// Throughput: one value per cycle unless output back-pressure stalls in_chan; at most one result per row.
// Pipeline: row/argmax register, multiply register, shift register, output register.
// Every stage has its own valid, so bubbles fill while a result waits at the output.
// Reset (rst_n, synchronous, active low) restores register defaults and starts a new row.
module detection_row_box_decode import drbd_pkg::*; #(
  parameter int MAX_CLASSES   = 80,
  parameter int FRACTION_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  drbd_in_if.sink           in_chan,
  drbd_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  row_res_t row_data;
  prod_t    prod_data;
  logic     row_valid, row_ready;
  logic     prod_valid, prod_ready;

  // shift stage (C) and output stage (D) control
  logic                      c_valid_r, c_ready, c_load;
  logic signed [VALUE_W-1:0] c_score_r;
  logic signed [CLASS_W-1:0] c_class_r;
  logic                      d_ready, d_load;
  logic                      out_valid_r;
  logic [PIX_W-1:0]          x_edge, x_size, y_edge, y_size;
  logic [PIX_W-1:0]          left_r, top_r, width_r, height_r;
  logic signed [VALUE_W-1:0] score_r;
  logic signed [CLASS_W-1:0] class_r;

  drbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // running argmax and row bookkeeping; threshold check at row end
  drbd_row #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_CLASSES   (MAX_CLASSES)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_value  (in_chan.value),
    .cfg       (cfg),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row_data  (row_data)
  );

  // four box multipliers: image size for normalized boxes, scale registers otherwise
  drbd_scale #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row_data   (row_data),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

  assign d_ready    = !out_valid_r || out_chan.ready;
  assign c_ready    = !c_valid_r || d_ready;
  assign prod_ready = c_ready;
  assign c_load     = prod_valid && c_ready;
  assign d_load     = c_valid_r && d_ready;

  // corner/size conversion and clamping, one unit per axis
  drbd_axis #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_x (
    .clk      (clk),
    .load     (c_load),
    .norm     (prod_data.norm),
    .p_c      (prod_data.pcx),
    .p_s      (prod_data.pw),
    .limit    (cfg.image_width),
    .box_edge (x_edge),
    .box_size (x_size)
  );

  drbd_axis #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_y (
    .clk      (clk),
    .load     (c_load),
    .norm     (prod_data.norm),
    .p_c      (prod_data.pcy),
    .p_s      (prod_data.ph),
    .limit    (cfg.image_height),
    .box_edge (y_edge),
    .box_size (y_size)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (c_load) begin
        c_valid_r <= 1'b1;
      end else if (d_ready) begin
        c_valid_r <= 1'b0;
      end
      if (d_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_score_r <= prod_data.best_score;
      c_class_r <= prod_data.best_class;
    end
    if (d_load) begin
      left_r   <= x_edge;
      width_r  <= x_size;
      top_r    <= y_edge;
      height_r <= y_size;
      score_r  <= c_score_r;
      class_r  <= c_class_r;
    end
  end

  // output transaction register
  assign out_chan.valid      = out_valid_r;
  assign out_chan.box_left   = left_r;
  assign out_chan.box_top    = top_r;
  assign out_chan.box_width  = width_r;
  assign out_chan.box_height = height_r;
  assign out_chan.best_class = class_r;
  assign out_chan.best_score = score_r;

endmodule
